// ===== rtl/cscan_pkg.sv =====
// ----------------------------------------------------------------------------
// cscan_pkg
// Shared types and constants of the circular-scan disk scheduler.
// ----------------------------------------------------------------------------
package cscan_pkg;

   localparam int unsigned REQ_CYL_W = 16;
   localparam int unsigned STOP_W    = 16;
   localparam int unsigned SEEK_W    = 24;
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [SEEK_W-1:0] SEEK_MAX = 24'hFFFFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_START_HEAD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISK_END   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_UP   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEAD,
      ST_PASS1,
      ST_END1,
      ST_END2,
      ST_PASS2
   } state_type;

   // Control broadcast to every cell of the store chain
   typedef struct packed {
      logic insert;      // sorted insertion of the incoming cylinder
      logic rot_up;      // each cell takes its lower neighbor, bottom takes top
      logic rot_down;    // each cell takes its upper neighbor, top takes bottom
   } cell_ctrl_type;

endpackage

// ===== rtl/cscan_cell.sv =====
// ----------------------------------------------------------------------------
// cscan_cell
// One entry of the sorted request chain: insert-by-compare and rotation.
// ----------------------------------------------------------------------------
module cscan_cell #(
   parameter int unsigned CYL_BITS = 16,
   parameter int unsigned CNT_W    = 6,
   parameter int unsigned IDX      = 0
) (
   input  logic                   clock,
   input  cscan_pkg::cell_ctrl_type ctrl,
   input  logic [CNT_W-1:0]       count,
   input  logic [CYL_BITS-1:0]    cyl,
   input  logic [CYL_BITS-1:0]    lower_val,
   input  logic                   lower_gt,
   input  logic [CYL_BITS-1:0]    upper_val,
   output logic [CYL_BITS-1:0]    val,
   output logic                   gt
);
   import cscan_pkg::*;

   logic [CYL_BITS-1:0] val_ff;
   logic [CYL_BITS-1:0] val_in;
   logic                occupied;
   logic                at_tail;

   assign occupied = (CNT_W'(IDX) < count);
   assign at_tail  = (CNT_W'(IDX) == count);
   assign gt       = occupied && (val_ff > cyl);
   assign val      = val_ff;

   always_comb begin
      val_in = val_ff;
      if (ctrl.insert) begin
         // shift the larger entries up by one, drop the new one into the gap
         if (gt || at_tail) begin
            val_in = lower_gt ? lower_val : cyl;
         end
      end else if (ctrl.rot_up) begin
         val_in = lower_val;
      end else if (ctrl.rot_down) begin
         val_in = upper_val;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

// ===== rtl/cscan_disk_scheduler.sv =====
// A request item is inserted in the cycle it is taken; ready stays high while loading.
// The batch-end item starts service: the head stop is registered in ST_HEAD once the output is
// free; ready returns after ST_PASS1, ST_END1, ST_END2 and ST_PASS2, which all wait on a free
// output, the two passes being two full rotations of the request chain past its read cell.
// Throughput: one request item per cycle while loading.
// Reset (synchronous, active high) empties the store and clears the output.
// ----------------------------------------------------------------------------
// cscan_disk_scheduler
// Sorted request chain with circular-scan service order and seek totals.
// ----------------------------------------------------------------------------
module cscan_disk_scheduler #(
   parameter int unsigned MAX_REQUESTS = 32,
   parameter int unsigned CYL_BITS     = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] request_cylinder
   input  logic        req_tlast,   // batch_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [15:0] stop_position, [39:16] seek_so_far
   output logic        rsp_tlast,   // sequence_end
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [cscan_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0] csr_wdata
);
   import cscan_pkg::*;

   localparam int unsigned CNT_W  = $clog2(MAX_REQUESTS + 1);
   localparam int unsigned MADE_W = $clog2(MAX_REQUESTS + 3);
   localparam int unsigned ROT_W  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int unsigned SUM_W  = ((CYL_BITS > SEEK_W) ? CYL_BITS : SEEK_W) + 1;

   state_type state_ff, state_in;

   logic [CYL_BITS-1:0] start_head_ff, start_head_in;
   logic [CYL_BITS-1:0] disk_end_ff, disk_end_in;
   logic                sweep_up_ff, sweep_up_in;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [MADE_W-1:0]   made_ff, made_in;
   logic [ROT_W-1:0]    rot_ff, rot_in;
   logic [CYL_BITS-1:0] head_now_ff, head_now_in;
   logic [SEEK_W-1:0]   seek_ff, seek_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [39:0]         rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;

   cell_ctrl_type       ctrl;
   logic [CYL_BITS-1:0] cyl;
   logic [CYL_BITS-1:0] cell_val [MAX_REQUESTS];
   logic                cell_gt  [MAX_REQUESTS];

   logic                req_take;
   logic                out_free;
   logic [CYL_BITS-1:0] scan_val;
   logic                scan_occ;
   logic                scan_below;
   logic                scan_sel;
   logic                pass2;
   logic                rot_last;
   logic                emit;
   logic [CYL_BITS-1:0] emit_pos;
   logic [CYL_BITS-1:0] seek_step;
   logic [SUM_W-1:0]    seek_sum;
   logic [SEEK_W-1:0]   seek_sat;
   logic                emit_last;

   assign cyl        = CYL_BITS'(req_tdata);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------------------------------------------------------- chain
   for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
      localparam int unsigned LO = (i == 0) ? MAX_REQUESTS - 1 : i - 1;
      localparam int unsigned HI = (i == MAX_REQUESTS - 1) ? 0 : i + 1;
      logic lower_gt;
      assign lower_gt = (i == 0) ? 1'b0 : cell_gt[LO];
      cscan_cell #(
         .CYL_BITS (CYL_BITS),
         .CNT_W    (CNT_W),
         .IDX      (i)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .count     (count_ff),
         .cyl       (cyl),
         .lower_val (cell_val[LO]),
         .lower_gt  (lower_gt),
         .upper_val (cell_val[HI]),
         .val       (cell_val[i]),
         .gt        (cell_gt[i])
      );
   end

   // ---------------------------------------------------------------- scan read
   // Upward reads cell 0 while rotating down (ascending); downward reads the
   // top cell while rotating up (descending). Either way rot_ff names the entry.
   assign scan_val   = sweep_up_ff ? cell_val[0] : cell_val[MAX_REQUESTS-1];
   assign scan_occ   = sweep_up_ff ? (CNT_W'(rot_ff) < count_ff)
                       : ((CNT_W'(MAX_REQUESTS - 1) - CNT_W'(rot_ff)) < count_ff);
   assign scan_below = (scan_val < start_head_ff);
   assign pass2      = (state_ff == ST_PASS2);
   assign scan_sel   = scan_occ && (scan_below == (pass2 ^ !sweep_up_ff));
   assign rot_last   = (rot_ff == ROT_W'(MAX_REQUESTS - 1));

   // ---------------------------------------------------------------- seek math
   assign seek_step = (emit_pos >= head_now_ff) ? emit_pos - head_now_ff
                                                : head_now_ff - emit_pos;
   assign seek_sum  = SUM_W'(seek_ff) + SUM_W'(seek_step);
   assign seek_sat  = (seek_sum > SUM_W'(SEEK_MAX)) ? SEEK_MAX : seek_sum[SEEK_W-1:0];
   assign emit_last = (made_ff == MADE_W'(count_ff) + MADE_W'(2));

   // ---------------------------------------------------------------- control
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      made_in       = made_ff;
      rot_in        = rot_ff;
      head_now_in   = head_now_ff;
      seek_in       = seek_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      ctrl          = '0;
      emit          = 1'b0;
      emit_pos      = scan_val;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (count_ff < CNT_W'(MAX_REQUESTS)) begin
                  ctrl.insert = 1'b1;
                  count_in    = count_ff + CNT_W'(1);
               end
               if (req_tlast) begin
                  state_in = ST_HEAD;
               end
            end
         end
         ST_HEAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {SEEK_W'(0), STOP_W'(start_head_ff)};
               rsp_last_in  = 1'b0;
               head_now_in  = start_head_ff;
               seek_in      = '0;
               made_in      = MADE_W'(1);
               rot_in       = '0;
               state_in     = ST_PASS1;
            end
         end
         ST_PASS1, ST_PASS2: begin
            if (out_free) begin
               emit          = scan_sel;
               ctrl.rot_up   = !sweep_up_ff;
               ctrl.rot_down = sweep_up_ff;
               rot_in        = rot_ff + ROT_W'(1);
               if (rot_last) begin
                  rot_in = '0;
                  if (pass2) begin
                     count_in = '0;
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_END1;
                  end
               end
            end
         end
         ST_END1: begin
            emit_pos = sweep_up_ff ? disk_end_ff : '0;
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_END2;
            end
         end
         ST_END2: begin
            emit_pos = sweep_up_ff ? '0 : disk_end_ff;
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_PASS2;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {seek_sat, STOP_W'(emit_pos)};
         rsp_last_in  = emit_last;
         head_now_in  = emit_pos;
         seek_in      = seek_sat;
         made_in      = made_ff + MADE_W'(1);
      end
   end

   // ---------------------------------------------------------------- csr
   always_comb begin
      start_head_in = start_head_ff;
      disk_end_in   = disk_end_ff;
      sweep_up_in   = sweep_up_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_START_HEAD: start_head_in = CYL_BITS'(csr_wdata);
            CSR_DISK_END:   disk_end_in   = CYL_BITS'(csr_wdata);
            CSR_SWEEP_UP:   sweep_up_in   = csr_wdata[0];
            default: begin
               start_head_in = start_head_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         made_ff       <= '0;
         rot_ff        <= '0;
         head_now_ff   <= '0;
         seek_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         start_head_ff <= '0;
         disk_end_ff   <= CYL_BITS'(16'hFFFF);
         sweep_up_ff   <= 1'b1;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         made_ff       <= made_in;
         rot_ff        <= rot_in;
         head_now_ff   <= head_now_in;
         seek_ff       <= seek_in;
         rsp_valid_ff  <= rsp_valid_in;
         start_head_ff <= start_head_in;
         disk_end_ff   <= disk_end_in;
         sweep_up_ff   <= sweep_up_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

// ===== rtl/cscan_checker.sv =====
// ----------------------------------------------------------------------------
// cscan_checker
// Port-level checks of the circular-scan disk scheduler.
// ----------------------------------------------------------------------------
module cscan_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   // stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp item changed while stalled");

   // a batch end closes the input until the sequence is served
   a_batch_closes: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input still open after batch end");

   // with the output free, the sequence starts with zero travel at the head stop
   a_first_stop: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast && (!rsp_tvalid || rsp_tready)
      |=> ##1 rsp_tvalid && rsp_tdata[39:16] == 24'd0)
      else $error("first stop has nonzero seek");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

endmodule

bind cscan_disk_scheduler cscan_checker u_cscan_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ===== verif/cscan_disk_scheduler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscan_disk_scheduler_tb
// Self-checking bench for the circular-scan disk scheduler. Request batches
// are streamed in under random backpressure on both sides. An in-bench
// scheduler model keeps its own sorted store and builds the expected stop
// sequence with running seek totals. Every stop leaving the block is
// compared with it field by field. A short table of hand-picked batches comes
// first, followed by random batches with register rewrites between them.
// ----------------------------------------------------------------------------
module cscan_disk_scheduler_tb;
   import cscan_pkg::*;

   localparam int MAX_REQ        = 32;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int SETTLE_CYCLES  = 16;
   localparam int TAIL_CYCLES    = 2 * MAX_REQ + 8;
   localparam int ITEMS_PER_PASS = 80;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [15:0] pos;
      logic [23:0] seek;
      logic        fin;
   } stop_type;

   typedef struct packed {
      logic        set_cfg;
      logic [15:0] head;
      logic [15:0] dend;
      logic        up;
      logic [15:0] cyl;
      logic        last;
      logic [2:0]  n_typed;
   } vector_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0] csr_wdata  = '0;

   // scheduler model state
   logic [15:0] cfg_head = 16'd0;
   logic [15:0] cfg_end  = 16'd65535;
   logic        cfg_up   = 1'b1;
   logic [15:0] held_cyls [MAX_REQ];
   int          held_count = 0;
   logic [15:0] head_pos = '0;
   logic [23:0] seek_run = '0;
   int          stop_idx;
   int          stop_total;

   stop_type   sweep_stops [$];
   stop_type   stops_due [$];
   stop_type   typed_book [$];
   vector_type vectors [$];
   int         typed_count = 0;

   int src_idle_pct = 0;
   int snk_idle_pct = 0;
   int cycle_count  = 0;
   int errors       = 0;
   int n_items      = 0;
   int n_batches    = 0;
   int n_dropped    = 0;
   int n_stops      = 0;
   int n_writes     = 0;

   cscan_disk_scheduler u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d stops outstanding", $time, stops_due.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= snk_idle_pct);
   end

   // ---------------------------------------------------------------- model
   task automatic log_stop(input logic [15:0] pos);
      logic [15:0] gap;
      logic [24:0] sum;
      stop_type    s;
      gap  = (pos >= head_pos) ? pos - head_pos : head_pos - pos;
      sum  = 25'(seek_run) + 25'(gap);
      seek_run = (sum > 25'(SEEK_MAX)) ? SEEK_MAX : sum[23:0];
      head_pos = pos;
      stop_idx++;
      s.pos  = pos;
      s.seek = seek_run;
      s.fin  = (stop_idx == stop_total);
      sweep_stops.push_back(s);
   endtask

   task automatic plan_sweep();
      int split;
      int i;
      sweep_stops.delete();
      head_pos   = cfg_head;
      seek_run   = '0;
      stop_idx   = 0;
      stop_total = held_count + 3;
      split = 0;
      while (split < held_count && held_cyls[split] < head_pos)
         split++;
      log_stop(head_pos);
      if (cfg_up) begin
         for (i = split; i < held_count; i++)
            log_stop(held_cyls[i]);
         log_stop(cfg_end);
         log_stop(16'd0);
         for (i = 0; i < split; i++)
            log_stop(held_cyls[i]);
      end else begin
         for (i = split; i > 0; i--)
            log_stop(held_cyls[i-1]);
         log_stop(16'd0);
         log_stop(cfg_end);
         for (i = held_count; i > split; i--)
            log_stop(held_cyls[i-1]);
      end
      held_count = 0;
   endtask

   task automatic note_request(input logic [15:0] cyl, input logic batch_end);
      int k;
      if (held_count < MAX_REQ) begin
         k = held_count;
         while (k > 0 && held_cyls[k-1] > cyl) begin
            held_cyls[k] = held_cyls[k-1];
            k--;
         end
         held_cyls[k] = cyl;
         held_count++;
      end else begin
         n_dropped++;
      end
      if (batch_end) begin
         n_batches++;
         plan_sweep();
         // hand-typed rows replace the computed sequence
         if (typed_count != 0) begin
            repeat (typed_count) stops_due.push_back(typed_book.pop_front());
            typed_count = 0;
         end else begin
            foreach (sweep_stops[i]) stops_due.push_back(sweep_stops[i]);
         end
      end
   endtask

   // -------------------------------------------------------------- monitor
   always @(posedge clock) begin
      stop_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            n_writes++;
            case (csr_index)
               CSR_START_HEAD: cfg_head = csr_wdata;
               CSR_DISK_END:   cfg_end  = csr_wdata;
               CSR_SWEEP_UP:   cfg_up   = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            n_items++;
            note_request(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            n_stops++;
            if (stops_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected stop, position %0d seek %0d last %0b",
                        $time, rsp_tdata[15:0], rsp_tdata[39:16], rsp_tlast);
            end else begin
               want = stops_due.pop_front();
               if (rsp_tdata[15:0] !== want.pos) begin
                  errors++;
                  $display("%0t: stop_position expected %0d actual %0d",
                           $time, want.pos, rsp_tdata[15:0]);
               end
               if (rsp_tdata[39:16] !== want.seek) begin
                  errors++;
                  $display("%0t: seek_so_far expected %0d actual %0d",
                           $time, want.seek, rsp_tdata[39:16]);
               end
               if (rsp_tlast !== want.fin) begin
                  errors++;
                  $display("%0t: sequence_end expected %0b actual %0b",
                           $time, want.fin, rsp_tlast);
               end
            end
         end
      end
   end

   // --------------------------------------------------------------- driver
   task automatic put_request(input logic [15:0] cyl, input logic batch_end);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= cyl;
      req_tlast  <= batch_end;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic apply_setup(input logic [15:0] head, input logic [15:0] dend,
                              input logic [15:0] up_word, input logic poke_unused);
      write_reg(CSR_START_HEAD, head);
      write_reg(CSR_DISK_END, dend);
      write_reg(CSR_SWEEP_UP, up_word);
      if (poke_unused)
         write_reg(CSR_UNUSED, 16'($urandom_range(0, 65535)));
      csr_valid <= 1'b0;
   endtask

   // drop valid, let the last batch drain and the block go idle, then wait a bit more
   task automatic settle(input int extra);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (stops_due.size() != 0) @(posedge clock);
      while (!req_tready) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic add_vector(input logic set_cfg, input logic [15:0] head,
                             input logic [15:0] dend, input logic up,
                             input logic [15:0] cyl, input logic last,
                             input int n_typed);
      vector_type v;
      v.set_cfg = set_cfg;
      v.head    = head;
      v.dend    = dend;
      v.up      = up;
      v.cyl     = cyl;
      v.last    = last;
      v.n_typed = 3'(n_typed);
      vectors.push_back(v);
   endtask

   task automatic add_stop(input logic [15:0] pos, input logic [23:0] seek, input logic fin);
      stop_type s;
      s.pos  = pos;
      s.seek = seek;
      s.fin  = fin;
      typed_book.push_back(s);
   endtask

   function automatic logic [15:0] pick_cyl();
      case ($urandom_range(5))
         0:       return 16'd0;
         1:       return 16'd65535;
         2:       return cfg_head;
         3:       return cfg_end;
         4:       return cfg_head + 16'($urandom_range(0, 4)) - 16'd2;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [15:0] pick_head();
      case ($urandom_range(3))
         0:       return 16'd0;
         1:       return 16'd65535;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [15:0] pick_end();
      case ($urandom_range(3))
         0:       return 16'd1;
         1:       return 16'd65535;
         default: return 16'($urandom_range(1, 65535));
      endcase
   endfunction

   initial begin
      vector_type v;
      int         burst;
      int         sent;
      int         k;

      // reset setup: one request at cylinder zero
      add_vector(0, 0, 0, 0, 16'd0, 1, 4);
      add_stop(16'd0, 24'd0, 0);
      add_stop(16'd0, 24'd0, 0);
      add_stop(16'd65535, 24'd65535, 0);
      add_stop(16'd0, 24'd131070, 1);
      // top cylinder, upward
      add_vector(1, 16'd0, 16'd65535, 1, 16'd65535, 1, 4);
      add_stop(16'd0, 24'd0, 0);
      add_stop(16'd65535, 24'd65535, 0);
      add_stop(16'd65535, 24'd65535, 0);
      add_stop(16'd0, 24'd131070, 1);
      // bottom cylinder, downward
      add_vector(1, 16'd0, 16'd65535, 0, 16'd0, 1, 4);
      add_stop(16'd0, 24'd0, 0);
      add_stop(16'd0, 24'd0, 0);
      add_stop(16'd65535, 24'd65535, 0);
      add_stop(16'd0, 24'd131070, 1);
      // head at top, smallest disk end
      add_vector(1, 16'd65535, 16'd1, 1, 16'd65535, 1, 4);
      add_stop(16'd65535, 24'd0, 0);
      add_stop(16'd65535, 24'd0, 0);
      add_stop(16'd1, 24'd65534, 0);
      add_stop(16'd0, 24'd65535, 1);
      // mixed batch upward, one request at the head and one past the end
      add_vector(1, 16'd100, 16'd200, 1, 16'd150, 0, 0);
      add_vector(0, 0, 0, 0, 16'd50, 0, 0);
      add_vector(0, 0, 0, 0, 16'd100, 0, 0);
      add_vector(0, 0, 0, 0, 16'd250, 0, 0);
      add_vector(0, 0, 0, 0, 16'd99, 0, 0);
      add_vector(0, 0, 0, 0, 16'd101, 1, 0);
      // same setup downward
      add_vector(1, 16'd100, 16'd200, 0, 16'd10, 0, 0);
      add_vector(0, 0, 0, 0, 16'd190, 0, 0);
      add_vector(0, 0, 0, 0, 16'd100, 0, 0);
      add_vector(0, 0, 0, 0, 16'd0, 0, 0);
      add_vector(0, 0, 0, 0, 16'd199, 0, 0);
      add_vector(0, 0, 0, 0, 16'd5, 1, 0);
      // head and end at the top, downward
      add_vector(1, 16'd65535, 16'd65535, 0, 16'd65535, 0, 0);
      add_vector(0, 0, 0, 0, 16'd32768, 0, 0);
      add_vector(0, 0, 0, 0, 16'd1, 1, 0);
      // alternating bit patterns
      add_vector(1, 16'd0, 16'd40000, 1, 16'h5555, 0, 0);
      add_vector(0, 0, 0, 0, 16'hAAAA, 0, 0);
      add_vector(0, 0, 0, 0, 16'd0, 1, 0);

      src_idle_pct = 8;
      snk_idle_pct = 59;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (vectors[i]) begin
         v = vectors[i];
         if (v.set_cfg) begin
            settle(SETTLE_CYCLES);
            apply_setup(v.head, v.dend, {15'd0, v.up}, 1'b0);
         end
         if (v.n_typed != 0)
            typed_count = v.n_typed;
         put_request(v.cyl, v.last);
      end

      for (int pass = 0; pass < 3; pass++) begin
         case (pass)
            0: begin
               src_idle_pct = 8;
               snk_idle_pct = 59;
            end
            1: begin
               src_idle_pct = 59;
               snk_idle_pct = 8;
            end
            default: begin
               src_idle_pct = 0;
               snk_idle_pct = 0;
            end
         endcase
         sent = 0;
         while (sent < ITEMS_PER_PASS) begin
            if ($urandom_range(3) == 0) begin
               settle(SETTLE_CYCLES);
               apply_setup(pick_head(), pick_end(), 16'($urandom_range(0, 65535)),
                           $urandom_range(3) == 0);
            end
            // now and then overfill the store so late requests get dropped
            burst = ($urandom_range(7) == 0) ? $urandom_range(33, 36) : $urandom_range(1, 6);
            for (k = 0; k < burst; k++)
               put_request(pick_cyl(), k == burst - 1);
            sent += burst;
         end
      end

      settle(TAIL_CYCLES);
      $display("Run covered %0d request items (%0d dropped on a full store) in %0d batches,",
               n_items, n_dropped, n_batches);
      $display("%0d stops checked, %0d register writes, %0d mismatches",
               n_stops, n_writes, errors);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
